>>> src/kdlmc_pkg.sv
// ============================================================================
// kdlmc_pkg
// Shared constants, types and helpers for the key debounce / LED mode block.
// ============================================================================
package kdlmc_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int KEY_IN_W   = 4;
    localparam int LED_OUT_W  = 4;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK      = 2'd2;

    localparam logic [CNT_W-1:0] PRESS_HOLD_RST = 8'd150;
    localparam logic [CNT_W-1:0] DEBOUNCE_RST   = 8'd5;
    localparam logic [CNT_W-1:0] BLINK_RST      = 8'd25;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    typedef struct packed {
        logic             tick;
        logic             refresh;
        logic [CNT_W-1:0] press_hold;
        logic [CNT_W-1:0] debounce;
    } kdl_cell_ctrl_t;

    typedef struct packed {
        logic ev_valid;
        logic ev_pressed;
        logic led_next;
    } kdl_cell_stat_t;

    function automatic logic [1:0] next_mode(input logic [1:0] m);
        logic [1:0] r;
        begin
            if (m >= MODE_BLINK)
                r = MODE_OFF;
            else
                r = m + 2'd1;
            return r;
        end
    endfunction

endpackage

>>> src/kdl_cell.sv
// ============================================================================
// kdl_cell
// One key: debounce counter, latch, LED mode and LED level. Passes the
// press-seen flag on to the next key in the chain.
// ============================================================================
module kdl_cell
    import kdlmc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  kdl_cell_ctrl_t ctrl,
    input  logic           is_main,
    input  logic           level_high,
    input  logic           seen_in,
    output logic           seen_out,
    output kdl_cell_stat_t stat
);

    logic [CNT_W-1:0] hold_reg, hold_next;
    logic             latched_reg, latched_next;
    logic [1:0]       mode_reg, mode_next;
    logic             led_reg;
    logic [CNT_W-1:0] hold_inc;
    logic [CNT_W-1:0] limit;
    logic             press_phase;

    assign hold_inc    = hold_reg + 8'd1;
    assign limit       = is_main ? ctrl.press_hold : ctrl.debounce;
    assign press_phase = !latched_reg && !level_high;
    assign seen_out    = seen_in || press_phase;

    always_comb
    begin
        hold_next       = 8'd0;
        latched_next    = latched_reg;
        mode_next       = mode_reg;
        stat.ev_valid   = 1'b0;
        stat.ev_pressed = 1'b0;
        if (latched_reg && level_high && seen_in)
        begin
            if (hold_inc == ctrl.debounce)
            begin
                latched_next  = 1'b0;
                mode_next     = next_mode(mode_reg);
                stat.ev_valid = is_main;
            end
            else
            begin
                hold_next = hold_inc;
            end
        end
        else if (press_phase)
        begin
            if (hold_inc == limit)
            begin
                latched_next    = 1'b1;
                stat.ev_valid   = is_main;
                stat.ev_pressed = is_main;
            end
            else
            begin
                hold_next = hold_inc;
            end
        end

        stat.led_next = led_reg;
        if (ctrl.refresh)
        begin
            case (mode_reg)
                MODE_OFF: stat.led_next = 1'b0;
                MODE_ON:  stat.led_next = 1'b1;
                default:  stat.led_next = ~led_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= 8'd0;
            latched_reg <= 1'b0;
            mode_reg    <= MODE_BLINK;
            led_reg     <= 1'b0;
        end
        else if (ctrl.tick)
        begin
            hold_reg    <= hold_next;
            latched_reg <= latched_next;
            mode_reg    <= mode_next;
            led_reg     <= stat.led_next;
        end
    end

endmodule

>>> src/kdl_blink_timer.sv
// ============================================================================
// kdl_blink_timer
// Tick counter that flags an LED refresh every blink_ticks ticks.
// ============================================================================
module kdl_blink_timer
    import kdlmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic [CNT_W-1:0] blink_ticks,
    output logic             refresh
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    assign cnt_inc  = cnt_reg + 8'd1;
    assign refresh  = tick && (cnt_inc == blink_ticks);
    assign cnt_next = (cnt_inc == blink_ticks) ? 8'd0 : cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 8'd0;
        else if (tick)
            cnt_reg <= cnt_next;
    end

endmodule

>>> src/key_debounce_led_mode_control.sv
// The result of each accepted input transfer is registered in the output register.
// Throughput: one tick per cycle when not stalled; cells and blink timer step per tick.
// The input side stalls only while a finished result is held and not taken.
// Reset: asynchronous, active low; registers return to defaults, LEDs off,
// all modes blink, no press seen.
// ============================================================================
// key_debounce_led_mode_control
// Per-key debounce chain with LED mode cycling, blink refresh and key reports.
// ============================================================================
module key_debounce_led_mode_control
    import kdlmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [3:0] key_levels
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [3:0] led_drive, [4] report0_valid,
                                                 // [5] report0_pressed, [6] report1_valid,
                                                 // [7] report1_pressed
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    logic [CNT_W-1:0] press_hold_reg, debounce_reg, blink_reg;
    logic             press_seen_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg, out_data_next;
    logic             s_fire;
    logic             refresh;
    kdl_cell_ctrl_t   ctrl;
    kdl_cell_stat_t   stat [NUM_KEYS];
    logic [NUM_KEYS:0] seen;
    logic [LED_OUT_W-1:0] led_drive;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_hold_reg <= PRESS_HOLD_RST;
            debounce_reg   <= DEBOUNCE_RST;
            blink_reg      <= BLINK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PRESS_HOLD: press_hold_reg <= cfg_data;
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_BLINK:      blink_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    kdl_blink_timer u_blink
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (s_fire),
        .blink_ticks (blink_reg),
        .refresh     (refresh)
    );

    assign ctrl.tick       = s_fire;
    assign ctrl.refresh    = refresh;
    assign ctrl.press_hold = press_hold_reg;
    assign ctrl.debounce   = debounce_reg;
    assign seen[0]         = press_seen_reg;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        logic level_high;
        if (k < KEY_IN_W)
        begin : g_pin
            assign level_high = s_axis_tdata[k];
        end
        else
        begin : g_nopin
            assign level_high = 1'b0;
        end

        kdl_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .is_main    (k < 2),
            .level_high (level_high),
            .seen_in    (seen[k]),
            .seen_out   (seen[k+1]),
            .stat       (stat[k])
        );

        if (k < LED_OUT_W)
        begin : g_led
            assign led_drive[k] = stat[k].led_next;
        end
    end

    for (genvar j = NUM_KEYS; j < LED_OUT_W; j++)
    begin : g_led_pad
        assign led_drive[j] = 1'b0;
    end

    assign out_data_next = {stat[1].ev_pressed, stat[1].ev_valid,
                            stat[0].ev_pressed, stat[0].ev_valid, led_drive};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_fire)
                press_seen_reg <= seen[NUM_KEYS];
            if (s_axis_tready)
                out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        press_seen_reg |=> press_seen_reg)
        else $error("press_seen cleared after being set");

    a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    a_rep0_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4])
        else $error("report0 kind set without valid");

    a_rep1_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6])
        else $error("report1 kind set without valid");
`endif

endmodule
